### hw/rtl/ursd_pkg.sv
// Shared types, constants and helper functions for the ultrasonic ranger servo drive.
// Used by every module of the block; depends on nothing else.
package ursd_pkg;

	// Register indexes of the configuration port.
	localparam logic [7:0] REG_SERVO_MIN = 8'd0;
	localparam logic [7:0] REG_SERVO_MAX = 8'd1;
	localparam logic [7:0] REG_NEAR_ECHO = 8'd2;
	localparam logic [7:0] REG_FAR_ECHO  = 8'd3;

	// Reset values of the configuration registers and of the pulse compare value.
	localparam logic [14:0] SERVO_MIN_RESET = 15'd700;
	localparam logic [14:0] SERVO_MAX_RESET = 15'd2100;
	localparam logic [15:0] NEAR_ECHO_RESET = 16'd290;
	localparam logic [15:0] FAR_ECHO_RESET  = 16'd1160;
	localparam logic [14:0] PULSE_RESET     = 15'd2100;

	// Level thresholds at 58 us per cm: 5, 10, 20, 40 and 60 cm.
	localparam logic [15:0] LED_TH0 = 16'd290;
	localparam logic [15:0] LED_TH1 = 16'd580;
	localparam logic [15:0] LED_TH2 = 16'd1160;
	localparam logic [15:0] LED_TH3 = 16'd2320;
	localparam logic [15:0] LED_TH4 = 16'd3480;

	// Depth of the queue between the tick front end and the mapping back end.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// Quotient bits of the mapping divide.
	localparam int QUOT_W = 15;

	typedef struct packed {
		logic [14:0] servo_min;
		logic [14:0] servo_max;
		logic [15:0] near_echo;
		logic [15:0] far_echo;
	} cfg_t;

	// One classified tick as it travels from the front end to the back end.
	typedef struct packed {
		logic        fall;
		logic        trig;
		logic [14:0] servo_count;
		logic [15:0] width;
	} tick_entry_t;

	function automatic logic [4:0] leds_for(input logic [15:0] w);
		logic [4:0] l;
		l[0] = (w > LED_TH0);
		l[1] = (w > LED_TH1);
		l[2] = (w > LED_TH2);
		l[3] = (w > LED_TH3);
		l[4] = (w > LED_TH4);
		return l;
	endfunction

endpackage

### hw/rtl/ursd_front.sv
// Front end: accepts echo ticks, runs the measurement and servo counters and classifies edges.
// Depends on ursd_pkg.
module ursd_front #(
	parameter int MEASURE_PERIOD = 50000,
	parameter int SERVO_PERIOD   = 20000,
	parameter int TRIGGER_TICKS  = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 echo_level,
	input  logic                 q_full,
	output logic                 q_push,
	output ursd_pkg::tick_entry_t q_entry
);
	import ursd_pkg::*;

	localparam logic [15:0] MEAS_LAST  = 16'(MEASURE_PERIOD - 1);
	localparam logic [14:0] SERVO_LAST = 15'(SERVO_PERIOD - 1);
	localparam logic [15:0] TRIG_LIMIT = 16'(TRIGGER_TICKS);

	logic [15:0] meas_count_q;
	logic [14:0] servo_count_q;
	logic        echo_prev_q;
	logic [15:0] rise_capture_q;
	logic        rise;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;
	assign rise     = echo_level && !echo_prev_q;

	always_comb begin
		q_entry.fall        = !echo_level && echo_prev_q;
		q_entry.trig        = (meas_count_q < TRIG_LIMIT);
		q_entry.servo_count = servo_count_q;
		q_entry.width       = meas_count_q - rise_capture_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_count_q   <= '0;
			servo_count_q  <= '0;
			echo_prev_q    <= 1'b0;
			rise_capture_q <= '0;
		end else if (q_push) begin
			echo_prev_q <= echo_level;
			if (rise) begin
				rise_capture_q <= meas_count_q;
			end
			meas_count_q  <= (meas_count_q == MEAS_LAST) ? '0 : meas_count_q + 16'd1;
			servo_count_q <= (servo_count_q == SERVO_LAST) ? '0 : servo_count_q + 15'd1;
		end
	end

endmodule

### hw/rtl/ursd_queue.sv
// Short queue of classified ticks between the front end and the back end.
// Depends on ursd_pkg.
module ursd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ursd_pkg::tick_entry_t push_entry,
	input  logic                  pop,
	output ursd_pkg::tick_entry_t head,
	output logic                  full,
	output logic                  empty
);
	import ursd_pkg::*;

	localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
	localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

	tick_entry_t       entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/ursd_back.sv
// Back end: updates width and LEDs, maps a falling-edge width onto the servo pulse
// with a shift-subtract divider, and holds the result register. Depends on ursd_pkg.
module ursd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ursd_pkg::cfg_t        cfg,
	input  logic                  q_empty,
	input  ursd_pkg::tick_entry_t head,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  trigger_out,
	output logic                  servo_out,
	output logic [4:0]            level_leds,
	output logic [15:0]           echo_width_us,
	output logic                  measure_done,
	output logic [14:0]           servo_pulse
);
	import ursd_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_FIN} back_state_t;

	localparam logic [3:0] DIV_LAST = 4'(QUOT_W - 1);

	back_state_t state_q;
	logic        out_valid_q;
	logic        trig_q;
	logic        servo_q;
	logic        done_q;
	logic [14:0] pulse_q;
	logic [4:0]  leds_q;
	logic [15:0] width_q;

	logic [15:0] diff_q;
	logic [14:0] span_q;
	logic [15:0] den_q;
	logic [15:0] rem_q;
	logic [14:0] quot_q;
	logic [14:0] base_q;
	logic [3:0]  div_cnt_q;

	logic        servo_now;
	logic        use_min;
	logic        use_max;
	logic [30:0] product;
	logic [16:0] trial;
	logic        trial_ge;
	logic [15:0] pulse_sum;

	assign q_pop     = (state_q == B_IDLE) && !q_empty && (!out_valid_q || out_ready);
	assign servo_now = (head.servo_count < pulse_q);
	assign use_min   = (cfg.servo_max < cfg.servo_min) || (head.width < cfg.near_echo)
	                   || (cfg.far_echo <= cfg.near_echo);
	assign use_max   = (head.width >= cfg.far_echo);
	assign product   = 31'(diff_q) * 31'(span_q);
	assign trial     = {rem_q, quot_q[QUOT_W-1]};
	assign trial_ge  = (trial >= {1'b0, den_q});
	assign pulse_sum = {1'b0, base_q} + {1'b0, quot_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			trig_q      <= 1'b0;
			servo_q     <= 1'b0;
			done_q      <= 1'b0;
			pulse_q     <= PULSE_RESET;
			leds_q      <= '0;
			width_q     <= '0;
			diff_q      <= '0;
			span_q      <= '0;
			den_q       <= '0;
			rem_q       <= '0;
			quot_q      <= '0;
			base_q      <= '0;
			div_cnt_q   <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						trig_q  <= head.trig;
						servo_q <= servo_now;
						if (!head.fall) begin
							done_q      <= 1'b0;
							out_valid_q <= 1'b1;
						end else begin
							width_q <= head.width;
							leds_q  <= leds_for(head.width);
							diff_q  <= head.width - cfg.near_echo;
							span_q  <= cfg.servo_max - cfg.servo_min;
							den_q   <= cfg.far_echo - cfg.near_echo;
							if (use_min) begin
								base_q  <= '0;
								quot_q  <= cfg.servo_min;
								state_q <= B_FIN;
							end else if (use_max) begin
								base_q  <= '0;
								quot_q  <= cfg.servo_max;
								state_q <= B_FIN;
							end else begin
								base_q  <= cfg.servo_min;
								state_q <= B_MUL;
							end
						end
					end
				end
				B_MUL: begin
					// The product is below den * 2^15, so its top half already fits below den.
					rem_q     <= product[30:15];
					quot_q    <= product[14:0];
					div_cnt_q <= '0;
					state_q   <= B_DIV;
				end
				B_DIV: begin
					rem_q     <= trial_ge ? 16'(trial - {1'b0, den_q}) : trial[15:0];
					quot_q    <= {quot_q[QUOT_W-2:0], trial_ge};
					div_cnt_q <= div_cnt_q + 4'd1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= B_FIN;
					end
				end
				B_FIN: begin
					pulse_q     <= pulse_sum[14:0];
					done_q      <= 1'b1;
					out_valid_q <= 1'b1;
					state_q     <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign trigger_out   = trig_q;
	assign servo_out     = servo_q;
	assign measure_done  = done_q;
	assign level_leds    = leds_q;
	assign echo_width_us = width_q;
	assign servo_pulse   = pulse_q;

`ifndef ASSERT_OFF
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");
	a_fin_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_FIN) |-> !out_valid_q)
		else $error("result register busy when mapping finished");
	a_plain_result: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !head.fall) |=> (out_valid_q && !done_q))
		else $error("tick without falling edge did not produce a plain result");
`endif

endmodule

### hw/rtl/ultrasonic_ranger_servo_drive.sv
// Top level of the ultrasonic ranger servo drive: configuration registers and the
// front end, queue and back end. Depends on ursd_pkg, ursd_front, ursd_queue, ursd_back.
//
// Usage: every request on the input channel is one microsecond tick carrying the sampled
// echo level. Each tick produces exactly one result request with the trigger level, the
// servo level, the five level LEDs, the last echo width, a measurement-done flag and the
// current servo pulse compare value. The config channel writes the four registers
// (servo minimum and maximum pulse, near and far echo width) by index; it is always
// ready and should be used only while no tick is in flight.
// A tick without a falling echo edge is pushed into the queue, popped by the back end and
// loaded into the result register. A falling edge whose width lies inside the near..far
// span is popped, passes the multiply state and the one-bit-per-cycle shift-subtract
// divider, then loads the result; one that falls back to the minimum or maximum pulse
// goes straight from the pop to the result load. Plain ticks sustain one per cycle while
// the receiver takes each result; a falling-edge tick holds the back end for its whole mapping.
// A two-entry queue between the tick front end and the mapping back end, plus the result
// register, lets input keep flowing while the receiver stalls; once both fill, in_ready
// drops until the receiver takes a result.
// Reset (arst_n low, asynchronous) clears the counters and edge state, sets the pulse
// compare value to 2100 and loads the register defaults 700, 2100, 290 and 1160.
module ultrasonic_ranger_servo_drive #(
	parameter int MEASURE_PERIOD = 50000,
	parameter int SERVO_PERIOD   = 20000,
	parameter int TRIGGER_TICKS  = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        echo_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        trigger_out,
	output logic        servo_out,
	output logic [4:0]  level_leds,
	output logic [15:0] echo_width_us,
	output logic        measure_done,
	output logic [14:0] servo_pulse,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ursd_pkg::*;

	cfg_t        cfg_q;
	tick_entry_t push_entry;
	tick_entry_t head;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;

	// Register writes are accepted every cycle; writes beyond the last index are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.servo_min <= SERVO_MIN_RESET;
			cfg_q.servo_max <= SERVO_MAX_RESET;
			cfg_q.near_echo <= NEAR_ECHO_RESET;
			cfg_q.far_echo  <= FAR_ECHO_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SERVO_MIN: cfg_q.servo_min <= cfg_data[14:0];
				REG_SERVO_MAX: cfg_q.servo_max <= cfg_data[14:0];
				REG_NEAR_ECHO: cfg_q.near_echo <= cfg_data;
				REG_FAR_ECHO:  cfg_q.far_echo  <= cfg_data;
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	// The front end counts ticks and classifies echo edges; the width of a pulse is
	// taken here so the back end only sees finished measurements.
	ursd_front #(
		.MEASURE_PERIOD (MEASURE_PERIOD),
		.SERVO_PERIOD   (SERVO_PERIOD),
		.TRIGGER_TICKS  (TRIGGER_TICKS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.echo_level (echo_level),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (push_entry)
	);

	ursd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty)
	);

	// The back end owns the pulse compare value, so the servo level of each tick is
	// resolved there against the value left by the previous tick.
	ursd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.head          (head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.trigger_out   (trigger_out),
		.servo_out     (servo_out),
		.level_leds    (level_leds),
		.echo_width_us (echo_width_us),
		.measure_done  (measure_done),
		.servo_pulse   (servo_pulse)
	);

endmodule

### tb/sv/testbench.sv
// Self-checking bench for the ultrasonic ranger servo drive: ticks go in, and every result
// is matched against a cycle-free prediction of the ranger kept inside this module.
// Depends on ursd_pkg and ultrasonic_ranger_servo_drive.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ursd_pkg::*;

	localparam int MEASURE_PERIOD = 50000;
	localparam int SERVO_PERIOD   = 20000;
	localparam int TRIGGER_TICKS  = 9;

	// Register indexes past the last real register; writes to them must change nothing.
	localparam logic [7:0] REG_SPARE_FIRST = REG_FAR_ECHO + 8'd1;
	localparam logic [7:0] REG_SPARE_LAST  = 8'hFF;

	// The receiver's long hold-off, long enough to fill the queue and the result register.
	localparam int HOLD_CYCLES = 400;
	// Cycle budget for a run of about 1500 ticks, several times what they need.
	localparam int CYCLE_LIMIT = 400_000;

	// One result request as the block should present it.
	typedef struct packed {
		logic        trig;
		logic        servo;
		logic [4:0]  leds;
		logic [15:0] width;
		logic        done;
		logic [14:0] pulse;
	} ranger_reading_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        echo_level = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        trigger_out;
	logic        servo_out;
	logic [4:0]  level_leds;
	logic [15:0] echo_width_us;
	logic        measure_done;
	logic [14:0] servo_pulse;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Echo samples waiting for the driver, and readings the block still owes us.
	bit              echo_ticks_todo[$];
	ranger_reading_t due_readings[$];

	int ticks_queued = 0;   // every queued tick is accepted in order, so this is the count
	int width_cap    = 8;   // longest random echo for the current register setting
	int errors       = 0;
	int hold_asked   = 0;   // bumped by the stimulus, served by the monitor
	bit idle_off     = 1'b0;
	int cycles       = 0;

	ultrasonic_ranger_servo_drive #(
		.MEASURE_PERIOD(MEASURE_PERIOD),
		.SERVO_PERIOD  (SERVO_PERIOD),
		.TRIGGER_TICKS (TRIGGER_TICKS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.echo_level   (echo_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.trigger_out  (trigger_out),
		.servo_out    (servo_out),
		.level_leds   (level_leds),
		.echo_width_us(echo_width_us),
		.measure_done (measure_done),
		.servo_pulse  (servo_pulse),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs on a handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Ranger prediction. It advances on each accepted tick and keeps its own copy of the
	// registers, updated on each accepted register write. Every tick owes one reading.
	always @(posedge clk) begin : track_ranger
		cfg_t            regs;
		logic [15:0]     meas_cnt;
		logic [14:0]     frame_cnt;
		logic            echo_last;
		logic [15:0]     rise_at;
		logic [15:0]     width_now;
		logic [14:0]     pulse_now;
		logic [4:0]      leds_now;
		logic [63:0]     scaled;
		ranger_reading_t r;
		if (!arst_n) begin
			regs.servo_min = SERVO_MIN_RESET;
			regs.servo_max = SERVO_MAX_RESET;
			regs.near_echo = NEAR_ECHO_RESET;
			regs.far_echo  = FAR_ECHO_RESET;
			meas_cnt  = '0;
			frame_cnt = '0;
			echo_last = 1'b0;
			rise_at   = '0;
			width_now = '0;
			pulse_now = PULSE_RESET;
			leds_now  = '0;
		end else begin
			// Only the low bits of a register survive; unknown indexes are dropped.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SERVO_MIN: regs.servo_min = cfg_data[14:0];
					REG_SERVO_MAX: regs.servo_max = cfg_data[14:0];
					REG_NEAR_ECHO: regs.near_echo = cfg_data;
					REG_FAR_ECHO:  regs.far_echo  = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				// Trigger and servo levels come from the counters and the pulse as they
				// stood before this tick, so a new pulse shows up one tick later.
				r.trig = (meas_cnt < TRIGGER_TICKS);
				r.servo = (frame_cnt < pulse_now);
				r.done = 1'b0;
				if (echo_level && !echo_last) begin
					rise_at = meas_cnt;
				end else if (!echo_level && echo_last) begin
					// Plain 16-bit difference, even when the counter wrapped at its period.
					width_now = meas_cnt - rise_at;
					// Short echoes, an empty or reversed near/far span and a reversed
					// pulse range all fall back to the minimum pulse.
					if (regs.servo_max < regs.servo_min || width_now < regs.near_echo ||
							regs.far_echo <= regs.near_echo) begin
						pulse_now = regs.servo_min;
					end else begin
						scaled = 64'(width_now - regs.near_echo) *
							64'(regs.servo_max - regs.servo_min);
						scaled = scaled / 64'(regs.far_echo - regs.near_echo) +
							64'(regs.servo_min);
						pulse_now = (scaled > 64'(regs.servo_max)) ? regs.servo_max :
							scaled[14:0];
					end
					leds_now = {width_now > LED_TH4, width_now > LED_TH3,
						width_now > LED_TH2, width_now > LED_TH1, width_now > LED_TH0};
					r.done = 1'b1;
				end
				echo_last = echo_level;
				meas_cnt  = (meas_cnt == MEASURE_PERIOD - 1) ? '0 : meas_cnt + 16'd1;
				frame_cnt = (frame_cnt == SERVO_PERIOD - 1) ? '0 : frame_cnt + 15'd1;
				r.leds  = leds_now;
				r.width = width_now;
				r.pulse = pulse_now;
				due_readings.push_back(r);
			end
		end
	end

	// Tick driver. After each accepted request it draws a random gap, or none while idle_off
	// is set; with no gap the next sample follows at once and valid simply stays high.
	always @(posedge clk) begin : drive_ticks
		int gap;
		int gap_left;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else if (in_valid && in_ready) begin
			gap = idle_off ? 0 : $urandom_range(0, 3);
			if (gap == 0 && echo_ticks_todo.size() > 0) begin
				echo_level <= echo_ticks_todo.pop_front();
			end else begin
				in_valid <= 1'b0;
				gap_left = gap;
			end
		end else if (!in_valid) begin
			if (gap_left > 0)
				gap_left--;
			if (gap_left == 0 && echo_ticks_todo.size() > 0) begin
				in_valid <= 1'b1;
				echo_level <= echo_ticks_todo.pop_front();
			end
		end
	end

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endtask

	// Result monitor. It checks each accepted request against the oldest reading owed,
	// then decides the next ready: a long hold when the stimulus asks for one, otherwise a
	// random stall after each request.
	always @(posedge clk) begin : watch_readings
		ranger_reading_t want;
		logic next_ready;
		int stall_left;
		int hold_left;
		int hold_seen;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			hold_seen = 0;
		end else begin
			next_ready = out_ready;
			if (out_valid && out_ready) begin
				if (due_readings.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual width %0d",
						$time, echo_width_us);
					errors++;
				end else begin
					want = due_readings.pop_front();
					check_field("trigger_out", int'(want.trig), int'(trigger_out));
					check_field("servo_out", int'(want.servo), int'(servo_out));
					check_field("level_leds", int'(want.leds), int'(level_leds));
					check_field("echo_width_us", int'(want.width), int'(echo_width_us));
					check_field("measure_done", int'(want.done), int'(measure_done));
					check_field("servo_pulse", int'(want.pulse), int'(servo_pulse));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				next_ready = (hold_left == 0);
			end else if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				hold_left = HOLD_CYCLES;
				next_ready = 1'b0;
			end else if (out_valid && out_ready) begin
				stall_left = idle_off ? 0 : $urandom_range(0, 3);
				next_ready = (stall_left == 0);
			end else if (!out_ready) begin
				if (stall_left > 0)
					stall_left--;
				next_ready = (stall_left == 0);
			end
			out_ready <= next_ready;
		end
	end

	task automatic push_tick(input bit level);
		echo_ticks_todo.push_back(level);
		ticks_queued++;
	endtask

	// An echo of high_len ticks followed by low_len low ticks; the width seen is high_len.
	task automatic push_pulse(input int high_len, input int low_len);
		repeat (high_len) push_tick(1'b1);
		repeat (low_len) push_tick(1'b0);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Write all four registers and size the random echoes so they straddle near and far.
	task automatic program_ranges(input logic [15:0] lo, input logic [15:0] hi,
			input logic [15:0] near_us, input logic [15:0] far_us);
		write_reg(REG_SERVO_MIN, lo);
		write_reg(REG_SERVO_MAX, hi);
		write_reg(REG_NEAR_ECHO, near_us);
		write_reg(REG_FAR_ECHO, far_us);
		width_cap = ((far_us > near_us) ? int'(far_us) : int'(near_us)) + 8;
		if (width_cap > 100)
			width_cap = 100;
		@(negedge clk);
	endtask

	// Sender pause: nothing left to send and no reading still owed.
	task automatic wait_for_idle();
		do @(negedge clk);
		while (echo_ticks_todo.size() != 0 || in_valid || due_readings.size() != 0);
	endtask

	initial begin : stimulus
		bit opening[24] = '{1, 1, 1, 0, 0, 1, 0, 1, 1, 1, 1, 0, 0, 0, 1, 0,
			1, 1, 0, 1, 0, 0, 1, 0};
		int led_widths[3] = '{1, 290, 291};
		int phase;
		int phase_start;
		int kind;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Opening ticks under the reset registers. The echo is already high on the first
		// tick, which counts as a rising edge at count zero, and the first nine ticks
		// carry the trigger. The short echoes all land below near.
		foreach (opening[i])
			push_tick(opening[i]);
		wait_for_idle();

		// Random echoes under a series of register settings, the extremes among them.
		for (phase = 0; phase < 10; phase++) begin
			case (phase)
				0: program_ranges(16'd0, 16'd19999, 16'd0, 16'd1);      // steepest slope
				1: program_ranges(16'd19999, 16'd0, 16'd5, 16'd30);     // max below min
				2: program_ranges(16'd1000, 16'd3000, 16'd20, 16'd20);  // empty span
				3: program_ranges(16'd300, 16'd9000, 16'd30, 16'd10);   // far below near
				4: begin
					// All-ones data loses bit 15; spare indexes must not disturb anything.
					program_ranges(16'hFFFF, 16'hFFFF, 16'd0, 16'd40);
					write_reg(REG_SPARE_FIRST, 16'h5A5A);
					write_reg(REG_SPARE_LAST, 16'hFFFF);
					@(negedge clk);
				end
				5: program_ranges(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
				7: program_ranges(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 12)), 16'($urandom_range(0, 60)));
				default: program_ranges(16'($urandom_range(0, 19999)),
					16'($urandom_range(0, 19999)), 16'($urandom_range(0, 30)),
					16'($urandom_range(0, 60)));
			endcase
			if (phase == 6)
				idle_off <= 1'b1;
			phase_start = ticks_queued;
			while (ticks_queued - phase_start < 90) begin
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					push_pulse($urandom_range(1, width_cap), $urandom_range(1, 8));
				end else if (kind < 9) begin
					push_pulse($urandom_range(1, 3), $urandom_range(1, 3));
				end else begin
					repeat ($urandom_range(4, 12)) push_tick(1'($urandom_range(0, 1)));
					push_tick(1'b0);
				end
			end
			// Stall the receiver for a long stretch while the driver keeps offering ticks,
			// so the queue fills and the input side has to back off.
			if (phase == 3)
				hold_asked <= hold_asked + 1;
			wait_for_idle();
			idle_off <= 1'b0;
		end

		// Back to the reset registers, with echoes just around the first LED threshold.
		program_ranges(16'(SERVO_MIN_RESET), 16'(SERVO_MAX_RESET), NEAR_ECHO_RESET,
			FAR_ECHO_RESET);
		foreach (led_widths[i])
			push_pulse(led_widths[i], $urandom_range(1, 4));
		wait_for_idle();

		// A short tail to catch anything the block sends after the last reading.
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
